### hdl/scp_pkg.sv
// Shared constants and controller/datapath interface types for second-chance replacement.
package scp_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 5;
    localparam int FIU_RESET     = 16;
    localparam int COUNT_W       = 32;

    typedef struct packed {
        logic load;
        logic lookup;
        logic hit_set;
        logic fill;
        logic count;
        logic rotate;
        logic evict;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic have_free;
        logic head_ref;
        logic out_free;
    } t_status;

endpackage

### hdl/scp_ctrl.sv
// Controller state machine sequencing lookup, fill, second-chance sweep and result output.
module scp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  scp_pkg::t_status i_status,
    output scp_pkg::t_cmd    o_cmd,
    output logic            o_in_stall
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.hit) begin
                    o_cmd.hit_set = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.count = 1'b1;
                    if (i_status.have_free) begin
                        o_cmd.fill = 1'b1;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                if (!i_status.head_ref) begin
                    o_cmd.evict = 1'b1;
                    n_state     = S_EMIT;
                end else begin
                    o_cmd.rotate = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### hdl/scp_datapath.sv
// Frame store, match logic, head rotation, fault counter and output register.
module scp_datapath #(
    parameter int FRAMES    = scp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = scp_pkg::PAGE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scp_pkg::t_cmd               i_cmd,
    output scp_pkg::t_status            o_status,
    input  logic                        i_cfg_valid,
    input  logic [scp_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [PAGE_BITS-1:0]        i_page_number,
    input  logic                        i_last_reference,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_page_fault,
    output logic                        o_evicted_valid,
    output logic [PAGE_BITS-1:0]        o_evicted_page,
    output logic [scp_pkg::COUNT_W-1:0] o_fault_total,
    output logic                        o_final_result
);

    localparam int NW = $clog2(FRAMES + 1);
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [scp_pkg::CFG_W-1:0]   r_cfg;
    logic [NW-1:0]               r_n;
    logic [31:0]                 n_n32;
    logic [PAGE_BITS-1:0]        r_page_in;
    logic                        r_last;
    logic                        r_hit;
    logic                        r_have_free;
    logic [IW-1:0]               r_hit_idx;
    logic [IW-1:0]               r_free_idx;
    logic                        n_hit;
    logic                        n_have_free;
    logic [IW-1:0]               n_hit_idx;
    logic [IW-1:0]               n_free_idx;
    logic                        r_ev_valid;
    logic [PAGE_BITS-1:0]        r_ev_page;
    logic [scp_pkg::COUNT_W-1:0] r_faults;

    logic [PAGE_BITS-1:0] r_fpage  [FRAMES];
    logic                 r_fvalid [FRAMES];
    logic                 r_fref   [FRAMES];

    logic                        r_out_valid;
    logic                        r_out_fault;
    logic                        r_out_ev_valid;
    logic [PAGE_BITS-1:0]        r_out_ev_page;
    logic [scp_pkg::COUNT_W-1:0] r_out_total;
    logic                        r_out_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= scp_pkg::CFG_W'(scp_pkg::FIU_RESET);
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // clamp frames in use to 1 .. FRAMES
    always_comb begin
        n_n32 = {{(32 - scp_pkg::CFG_W){1'b0}}, r_cfg};
        if (n_n32 == 32'd0) begin
            n_n32 = 32'd1;
        end else if (n_n32 > 32'(FRAMES)) begin
            n_n32 = 32'(FRAMES);
        end
    end

    assign r_n = n_n32[NW-1:0];

    always_comb begin
        n_hit       = 1'b0;
        n_hit_idx   = '0;
        n_have_free = 1'b0;
        n_free_idx  = '0;
        for (int j = 0; j < FRAMES; j++) begin
            if ((NW'(j) < r_n) && r_fvalid[j] && (r_fpage[j] == r_page_in)) begin
                n_hit     = 1'b1;
                n_hit_idx = IW'(j);
            end
        end
        for (int j = FRAMES - 1; j >= 0; j--) begin
            if ((NW'(j) < r_n) && !r_fvalid[j]) begin
                n_have_free = 1'b1;
                n_free_idx  = IW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page_in <= i_page_number;
            r_last    <= i_last_reference;
        end
        if (i_cmd.lookup) begin
            r_hit       <= n_hit;
            r_have_free <= n_have_free;
            r_hit_idx   <= n_hit_idx;
            r_free_idx  <= n_free_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
            r_faults   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ev_valid <= 1'b0;
            end else if (i_cmd.evict) begin
                r_ev_valid <= r_fvalid[0];
            end
            if (i_cmd.count) begin
                r_faults <= r_faults + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ev_page <= '0;
        end else if (i_cmd.evict) begin
            r_ev_page <= r_fvalid[0] ? r_fpage[0] : '0;
        end
    end

    for (genvar j = 0; j < FRAMES; j++) begin : g_frame
        localparam int NEXT = (j + 1 < FRAMES) ? j + 1 : j;

        logic                 w_shift;
        logic                 w_tail;
        logic                 w_sel;
        logic [PAGE_BITS-1:0] n_page;
        logic                 n_valid;
        logic                 n_ref;

        assign w_shift = (NW'(j + 1) < r_n);
        assign w_tail  = (NW'(j + 1) == r_n);
        assign w_sel   = (IW'(j) == r_hit_idx);

        always_comb begin
            n_page  = r_fpage[j];
            n_valid = r_fvalid[j];
            n_ref   = r_fref[j];
            if (i_cmd.rotate || i_cmd.evict) begin
                if (w_shift) begin
                    n_page  = r_fpage[NEXT];
                    n_valid = r_fvalid[NEXT];
                    n_ref   = r_fref[NEXT];
                end else if (w_tail) begin
                    if (i_cmd.evict) begin
                        n_page  = r_page_in;
                        n_valid = 1'b1;
                        n_ref   = 1'b1;
                    end else begin
                        n_page  = r_fpage[0];
                        n_valid = r_fvalid[0];
                        n_ref   = 1'b0;
                    end
                end
            end else if (i_cmd.hit_set && w_sel) begin
                n_ref = 1'b1;
            end else if (i_cmd.fill && (IW'(j) == r_free_idx)) begin
                n_page  = r_page_in;
                n_valid = 1'b1;
                n_ref   = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_fpage[j] <= n_page;
            if (!i_rst_n) begin
                r_fvalid[j] <= 1'b0;
                r_fref[j]   <= 1'b0;
            end else begin
                r_fvalid[j] <= n_valid;
                r_fref[j]   <= n_ref;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_fault    <= !r_hit;
            r_out_ev_valid <= r_ev_valid;
            r_out_ev_page  <= r_ev_page;
            r_out_total    <= r_faults;
            r_out_final    <= r_last;
        end
    end

    assign o_status.hit       = r_hit;
    assign o_status.have_free = r_have_free;
    assign o_status.head_ref  = r_fref[0];
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_page_fault    = r_out_fault;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_out_total;
    assign o_final_result  = r_out_final;

endmodule

### hdl/second_chance_page_replacement.sv
// Top level of the second-chance page replacement block.
// One page reference is taken at a time. A hit or a miss that finds a free
// frame passes through the lookup, decide and emit states before the result
// register is written, and the next request is accepted once the controller
// is back in idle. A miss with every managed frame full first runs the
// second-chance sweep of 1 to n+1 head examinations (n = effective frames in use),
// since the FIFO head rotates one entry per cycle. The result sits in an
// output register, so the next request is accepted while it waits to be taken;
// that request's result is held back until the earlier one has been taken.
// frames_in_use of 0 acts as 1, above FRAMES as FRAMES; write it only while idle.
module second_chance_page_replacement #(
    parameter int FRAMES    = scp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = scp_pkg::PAGE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [scp_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [PAGE_BITS-1:0]        i_page_number,
    input  logic                        i_last_reference,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_page_fault,
    output logic                        o_evicted_valid,
    output logic [PAGE_BITS-1:0]        o_evicted_page,
    output logic [scp_pkg::COUNT_W-1:0] o_fault_total,
    output logic                        o_final_result
);

    scp_pkg::t_cmd    w_cmd;
    scp_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    scp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    scp_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_page_number    (i_page_number),
        .i_last_reference (i_last_reference),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_page_fault     (o_page_fault),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_page   (o_evicted_page),
        .o_fault_total    (o_fault_total),
        .o_final_result   (o_final_result)
    );

endmodule

### tb/sv/scp_checker.sv
// Request and result monitor with second-chance replacement predictor and result comparison.
`timescale 1ns / 100ps
module scp_checker #(
    parameter int FRAMES    = scp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = scp_pkg::PAGE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [scp_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [PAGE_BITS-1:0]        i_page_number,
    input  logic                        i_last_reference,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_page_fault,
    input  logic                        i_evicted_valid,
    input  logic [PAGE_BITS-1:0]        i_evicted_page,
    input  logic [scp_pkg::COUNT_W-1:0] i_fault_total,
    input  logic                        i_final_result,
    output int                          o_mismatches,
    output int                          o_outstanding
);

    typedef struct packed {
        logic                        page_fault;
        logic                        evicted_valid;
        logic [PAGE_BITS-1:0]        evicted_page;
        logic [scp_pkg::COUNT_W-1:0] fault_total;
        logic                        final_result;
    } t_outcome;

    logic [PAGE_BITS-1:0]        frame_page   [FRAMES];
    logic                        frame_valid  [FRAMES];
    logic                        frame_refbit [FRAMES];
    logic [scp_pkg::COUNT_W-1:0] fault_count;
    logic [scp_pkg::CFG_W-1:0]   frames_cfg;
    t_outcome                    expected_q [$];
    int                          mismatch_count;

    function automatic t_outcome resolve_reference(logic [PAGE_BITS-1:0] page, logic last);
        t_outcome             res;
        int                   n;
        int                   j;
        int                   k;
        bit                   hit;
        int                   hit_idx;
        bit                   have_free;
        int                   free_idx;
        bit                   done;
        logic [PAGE_BITS-1:0] hp;
        logic                 hv;
        res = '0;
        n = frames_cfg;
        if (n == 0) n = 1;
        if (n > FRAMES) n = FRAMES;
        hit = 0;
        hit_idx = 0;
        have_free = 0;
        free_idx = 0;
        for (j = 0; j < n; j++) begin
            if (frame_valid[j] && frame_page[j] == page) begin
                hit = 1;
                hit_idx = j;
            end
            if (!frame_valid[j] && !have_free) begin
                have_free = 1;
                free_idx = j;
            end
        end
        if (hit) begin
            frame_refbit[hit_idx] = 1'b1;
        end else begin
            fault_count = fault_count + 1'b1;
            if (have_free) begin
                frame_page[free_idx]   = page;
                frame_valid[free_idx]  = 1'b1;
                frame_refbit[free_idx] = 1'b1;
            end else begin
                done = 0;
                for (k = 0; k <= n && !done; k++) begin
                    hp = frame_page[0];
                    hv = frame_valid[0];
                    if (!frame_refbit[0]) begin
                        res.evicted_valid = hv;
                        res.evicted_page  = hv ? hp : '0;
                        hp = page;
                        hv = 1'b1;
                        done = 1;
                    end
                    for (j = 0; j + 1 < n; j++) begin
                        frame_page[j]   = frame_page[j + 1];
                        frame_valid[j]  = frame_valid[j + 1];
                        frame_refbit[j] = frame_refbit[j + 1];
                    end
                    frame_page[n - 1]   = hp;
                    frame_valid[n - 1]  = hv;
                    frame_refbit[n - 1] = done;
                end
            end
        end
        res.page_fault   = !hit;
        res.fault_total  = fault_count;
        res.final_result = last;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_outcome exp_r;
        t_outcome got_r;
        if (!i_rst_n) begin
            for (int j = 0; j < FRAMES; j++) begin
                frame_page[j]   = '0;
                frame_valid[j]  = 1'b0;
                frame_refbit[j] = 1'b0;
            end
            fault_count = '0;
            frames_cfg = scp_pkg::CFG_W'(scp_pkg::FIU_RESET);
            expected_q.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) frames_cfg = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(resolve_reference(i_page_number, i_last_reference));
            end
            if (i_out_valid && !i_out_stall) begin
                got_r = {i_page_fault, i_evicted_valid, i_evicted_page,
                         i_fault_total, i_final_result};
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no request outstanding: %h", $realtime, got_r);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r !== exp_r) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: exp %0b %0b %h %0d %0b got %0b %0b %h %0d %0b",
                                     $realtime, exp_r.page_fault, exp_r.evicted_valid,
                                     exp_r.evicted_page, exp_r.fault_total, exp_r.final_result,
                                     got_r.page_fault, got_r.evicted_valid,
                                     got_r.evicted_page, got_r.fault_total,
                                     got_r.final_result);
                    end
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_q.size();
    end

endmodule

### tb/sv/testbench.sv
// Top of the second-chance replacement testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

    localparam int FRAMES          = scp_pkg::FRAMES_DEF;
    localparam int PAGE_BITS       = scp_pkg::PAGE_BITS_DEF;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASE_ITEMS     = 140;
    localparam int POOL_SIZE       = 24;
    localparam int PRESSURE_AT     = 120;
    localparam int PRESSURE_CYCLES = 300;

    logic                        i_clk            = 1'b0;
    logic                        i_rst_n          = 1'b0;
    logic                        i_cfg_valid      = 1'b0;
    logic [scp_pkg::CFG_W-1:0]   i_cfg_data       = '0;
    logic                        i_in_valid       = 1'b0;
    logic [PAGE_BITS-1:0]        i_page_number    = '0;
    logic                        i_last_reference = 1'b0;
    logic                        i_out_stall      = 1'b0;
    logic                        o_cfg_ready;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic                        o_page_fault;
    logic                        o_evicted_valid;
    logic [PAGE_BITS-1:0]        o_evicted_page;
    logic [scp_pkg::COUNT_W-1:0] o_fault_total;
    logic                        o_final_result;
    int                          mismatches;
    int                          outstanding;
    int                          send_mode = 1;
    int                          recv_mode = 1;
    int                          results_taken = 0;
    logic [PAGE_BITS-1:0]        page_pool [POOL_SIZE];
    logic [scp_pkg::CFG_W-1:0]   phase_frames [10] = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd8,
                                                       5'd31, 5'd2, 5'd17, 5'd5, 5'd16};

    second_chance_page_replacement #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_page_number(i_page_number), .i_last_reference(i_last_reference),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_page_fault(o_page_fault), .o_evicted_valid(o_evicted_valid),
        .o_evicted_page(o_evicted_page), .o_fault_total(o_fault_total),
        .o_final_result(o_final_result)
    );

    scp_checker #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_page_number(i_page_number), .i_last_reference(i_last_reference),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_page_fault(o_page_fault), .i_evicted_valid(o_evicted_valid),
        .i_evicted_page(o_evicted_page), .i_fault_total(o_fault_total),
        .i_final_result(o_final_result),
        .o_mismatches(mismatches), .o_outstanding(outstanding)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int draw_gap(int mode);
        return (mode == 0) ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_reference(logic [PAGE_BITS-1:0] page, logic last);
        int gap;
        gap = draw_gap(send_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_page_number    <= page;
        i_last_reference <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_frames(logic [scp_pkg::CFG_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int hold;
        forever begin
            hold = (results_taken == PRESSURE_AT) ? PRESSURE_CYCLES : draw_gap(recv_mode);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            results_taken++;
        end
    end

    initial begin : stimulus
        int                   n;
        int                   span;
        int                   sel;
        logic [PAGE_BITS-1:0] page;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_reference('0, 1'b0);
        send_reference('1, 1'b0);
        send_reference('0, 1'b0);
        send_reference('1, 1'b1);
        send_reference(16'h5A5A, 1'b0);
        send_reference(16'hA5A5, 1'b0);
        write_frames(5'd1);
        send_reference('0, 1'b0);
        send_reference(16'd7, 1'b0);
        send_reference(16'd8, 1'b0);
        write_frames(5'd0);
        send_reference(16'd8, 1'b0);
        send_reference(16'd9, 1'b1);
        write_frames(5'd31);
        send_reference(16'h5A5A, 1'b0);
        send_reference('0, 1'b0);
        // leave a stale copy beyond the managed range, then widen to expose it
        write_frames(5'd2);
        send_reference(16'hA5A5, 1'b0);
        write_frames(5'd4);
        send_reference(16'hA5A5, 1'b0);
        send_reference(16'h1234, 1'b0);

        for (int p = 0; p < 10; p++) begin
            write_frames(phase_frames[p]);
            n = phase_frames[p];
            if (n == 0) n = 1;
            if (n > FRAMES) n = FRAMES;
            span = (n + 3 < POOL_SIZE) ? n + 3 : POOL_SIZE - 1;
            for (int j = 0; j < POOL_SIZE; j++) page_pool[j] = PAGE_BITS'($urandom);
            send_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            recv_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                sel = $urandom_range(0, 9);
                if (sel < 7) page = page_pool[$urandom_range(0, span)];
                else if (sel < 9) page = PAGE_BITS'($urandom);
                else page = $urandom_range(0, 1) ? '1 : '0;
                send_reference(page, $urandom_range(0, 19) == 0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/scp_pkg.sv
hdl/scp_ctrl.sv
hdl/scp_datapath.sv
hdl/second_chance_page_replacement.sv
tb/sv/scp_checker.sv
tb/sv/testbench.sv
